FILE: hw/rtl/mlfq_slot_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot scheduler
// Implication checks, same-cycle and next-cycle; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MLFQ_SLOT_SCHEDULER_ASSERT_SVH
`define MLFQ_SLOT_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MLFQ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlfq assertion failed");
`define MLFQ_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlfq assertion failed");
`else
`define MLFQ_ASSERT_IMP(name, clk, rst, ante, cons)
`define MLFQ_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_JOBS_DEF  = 32;
  localparam int SLOT_BITS_DEF = 16;

  // register reset values
  localparam logic [15:0] QUANTUM0_RST  = 16'd1;
  localparam logic [15:0] QUANTUM1_RST  = 16'd20;
  localparam logic [15:0] QUANTUM2_RST  = 16'd30;
  localparam logic [7:0]  AGE_UNIT_RST  = 8'd35;
  localparam logic [7:0]  AGE_LIMIT_RST = 8'd17;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_UNIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 3'd4;

  // input operations
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // datapath commands
  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_ACCEPT   = 5'd1;
  localparam logic [CMD_W-1:0] CMD_AG_QRD   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_AG_JRD   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_AG_UPD   = 5'd4;
  localparam logic [CMD_W-1:0] CMD_AG_END   = 5'd5;
  localparam logic [CMD_W-1:0] CMD_INS_QRD  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_INS_JRD  = 5'd7;
  localparam logic [CMD_W-1:0] CMD_INS_MOVE = 5'd8;
  localparam logic [CMD_W-1:0] CMD_INS_PUT  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_PR_RD    = 5'd10;
  localparam logic [CMD_W-1:0] CMD_PR_ACT   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_DS_QRD   = 5'd12;
  localparam logic [CMD_W-1:0] CMD_DS_JRD   = 5'd13;
  localparam logic [CMD_W-1:0] CMD_DS_RUN   = 5'd14;
  localparam logic [CMD_W-1:0] CMD_SH_RD    = 5'd15;
  localparam logic [CMD_W-1:0] CMD_SH_WR    = 5'd16;
  localparam logic [CMD_W-1:0] CMD_OUT_DONE = 5'd17;

  typedef struct packed {
    logic [CMD_W-1:0] op;
  } mlfq_cmd_t;

  typedef struct packed {
    logic tick;         // word on the input is a tick
    logic ag_done;      // aging walk reached the end of level 3
    logic promote;      // aged job hits the limit
    logic j_zero;       // insert cursor at queue head
    logic ins_move;     // entry ahead holds more remaining slots
    logic running;
    logic reinsert;     // running job goes back into a level
    logic dispatch_go;  // idle and some level holds a job
    logic shift_done;   // queue compaction after dispatch finished
  } mlfq_stat_t;

endpackage

FILE: hw/rtl/mlfq_ifs.sv
// ----------------------------------------------------------------------------
// mlfq channel interfaces
// Input, result and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  job_id;
  logic        low_priority;
  logic [15:0] service_slots;
  modport source (output valid, operation, job_id, low_priority, service_slots,
                  input ready);
  modport sink (input valid, operation, job_id, low_priority, service_slots,
                output ready);
endinterface

interface mlfq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] slot_time;
  logic [4:0]  running_job;
  logic        machine_idle;
  logic        all_empty;
  modport source (output valid, slot_time, running_job, machine_idle, all_empty,
                  input ready);
  modport sink (input valid, slot_time, running_job, machine_idle, all_empty,
                output ready);
endinterface

interface mlfq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/mlfq_slot_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_slot_scheduler
// Four-level feedback-queue slot scheduler with aging of level-3 jobs.
// ----------------------------------------------------------------------------
// An arrive word registers a job at the tail of FIFO level 0; duplicates, ids
// beyond MAX_JOBS and zero-slot jobs are dropped. A tick word ages level 3,
// preempts or expires the running job, dispatches the head of the highest
// non-empty level and returns one result word. After the accept a tick walks
// the n3 jobs in level 3, r sorted inserts stepping over m entries in all, and
// d entries shifted up after a dispatch, then waits on any output stall. Its
// length is set by the job table and level-queue memory, each with one
// registered read port and one write port, walked one entry at a time; the
// worst case at 32 jobs is every level-3 job promoted into a growing level 1.
// One word is in work at a time. The user must write registers through the
// cfg channel only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mlfq_slot_scheduler #(
  parameter int MAX_JOBS  = mlfq_pkg::MAX_JOBS_DEF,
  parameter int SLOT_BITS = mlfq_pkg::SLOT_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  mlfq_in_if.sink      in,
  mlfq_out_if.source   out,
  mlfq_cfg_if.sink     cfg
);
  import mlfq_pkg::*;

  mlfq_cmd_t  cmd;
  mlfq_stat_t stat;

  // register writes never stall
  assign cfg.ready = 1'b1;

  mlfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlfq_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .SLOT_BITS (SLOT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in.operation),
    .in_job_id        (in.job_id),
    .in_low_priority  (in.low_priority),
    .in_service_slots (in.service_slots),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .slot_time        (out.slot_time),
    .running_job      (out.running_job),
    .machine_idle     (out.machine_idle),
    .all_empty        (out.all_empty)
  );

endmodule

FILE: hw/rtl/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: walks one tick through aging, preemption, dispatch and output.
// ----------------------------------------------------------------------------
`include "mlfq_slot_scheduler_assert.svh"

module mlfq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mlfq_pkg::mlfq_stat_t stat,
  output mlfq_pkg::mlfq_cmd_t  cmd
);
  import mlfq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_AG_CHK  = 4'd1;
  localparam logic [3:0] S_AG_JRD  = 4'd2;
  localparam logic [3:0] S_AG_UPD  = 4'd3;
  localparam logic [3:0] S_INS_CHK = 4'd4;
  localparam logic [3:0] S_INS_JRD = 4'd5;
  localparam logic [3:0] S_INS_CMP = 4'd6;
  localparam logic [3:0] S_PR_RD   = 4'd7;
  localparam logic [3:0] S_PR_ACT  = 4'd8;
  localparam logic [3:0] S_DS_SEL  = 4'd9;
  localparam logic [3:0] S_DS_JRD  = 4'd10;
  localparam logic [3:0] S_DS_RUN  = 4'd11;
  localparam logic [3:0] S_SH_CHK  = 4'd12;
  localparam logic [3:0] S_SH_WR   = 4'd13;
  localparam logic [3:0] S_OUT     = 4'd14;

  logic [3:0] state, state_next;
  logic       ret_ag, ret_ag_next;   // insert returns to aging walk
  logic [3:0] ret_state;

  assign ret_state = ret_ag ? S_AG_CHK : S_DS_SEL;

  always_comb begin
    state_next  = state;
    ret_ag_next = ret_ag;
    cmd.op      = CMD_NOP;
    in_ready    = (state == S_IDLE);
    out_valid   = (state == S_OUT);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = CMD_ACCEPT;
          if (stat.tick) state_next = S_AG_CHK;
        end
      end
      S_AG_CHK: begin
        if (stat.ag_done) begin
          cmd.op     = CMD_AG_END;
          state_next = S_PR_RD;
        end else begin
          cmd.op     = CMD_AG_QRD;
          state_next = S_AG_JRD;
        end
      end
      S_AG_JRD: begin
        cmd.op     = CMD_AG_JRD;
        state_next = S_AG_UPD;
      end
      S_AG_UPD: begin
        cmd.op = CMD_AG_UPD;
        if (stat.promote) begin
          ret_ag_next = 1'b1;
          state_next  = S_INS_CHK;
        end else begin
          state_next = S_AG_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat.j_zero) begin
          cmd.op     = CMD_INS_PUT;
          state_next = ret_state;
        end else begin
          cmd.op     = CMD_INS_QRD;
          state_next = S_INS_JRD;
        end
      end
      S_INS_JRD: begin
        cmd.op     = CMD_INS_JRD;
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (stat.ins_move) begin
          cmd.op     = CMD_INS_MOVE;
          state_next = S_INS_CHK;
        end else begin
          cmd.op     = CMD_INS_PUT;
          state_next = ret_state;
        end
      end
      S_PR_RD: begin
        if (stat.running) begin
          cmd.op     = CMD_PR_RD;
          state_next = S_PR_ACT;
        end else begin
          state_next = S_DS_SEL;
        end
      end
      S_PR_ACT: begin
        cmd.op = CMD_PR_ACT;
        if (stat.reinsert) begin
          ret_ag_next = 1'b0;
          state_next  = S_INS_CHK;
        end else begin
          state_next = S_DS_SEL;
        end
      end
      S_DS_SEL: begin
        if (stat.dispatch_go) begin
          cmd.op     = CMD_DS_QRD;
          state_next = S_DS_JRD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DS_JRD: begin
        cmd.op     = CMD_DS_JRD;
        state_next = S_DS_RUN;
      end
      S_DS_RUN: begin
        cmd.op     = CMD_DS_RUN;
        state_next = S_SH_CHK;
      end
      S_SH_CHK: begin
        if (stat.shift_done) begin
          state_next = S_OUT;
        end else begin
          cmd.op     = CMD_SH_RD;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.op     = CMD_SH_WR;
        state_next = S_SH_CHK;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.op     = CMD_OUT_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret_ag <= 1'b0;
    end else begin
      state  <= state_next;
      ret_ag <= ret_ag_next;
    end
  end

  `MLFQ_ASSERT_IMP(a_ready_excl, clk, rst, in_ready, !out_valid)
  `MLFQ_ASSERT_NXT(a_word_release, clk, rst, out_valid && out_ready, in_ready)
  `MLFQ_ASSERT_NXT(a_arrive_one, clk, rst, in_valid && in_ready && !stat.tick, in_ready)

endmodule

FILE: hw/rtl/mlfq_dp.sv
// ----------------------------------------------------------------------------
// mlfq_dp
// Job table, level queue memory, counters and slot arithmetic.
// ----------------------------------------------------------------------------
`include "mlfq_slot_scheduler_assert.svh"

module mlfq_dp #(
  parameter int MAX_JOBS  = mlfq_pkg::MAX_JOBS_DEF,
  parameter int SLOT_BITS = mlfq_pkg::SLOT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mlfq_pkg::mlfq_cmd_t           cmd,
  output mlfq_pkg::mlfq_stat_t          stat,
  input  logic                          in_operation,
  input  logic [4:0]                    in_job_id,
  input  logic                          in_low_priority,
  input  logic [15:0]                   in_service_slots,
  input  logic                          cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic [31:0]                   slot_time,
  output logic [4:0]                    running_job,
  output logic                          machine_idle,
  output logic                          all_empty
);
  import mlfq_pkg::*;

  // ids are 5 bits, so at most 32 jobs can ever be live
  localparam int JOB_CNT = (MAX_JOBS < 32) ? MAX_JOBS : 32;
  localparam int JW      = $clog2(JOB_CNT);
  localparam int CW      = $clog2(JOB_CNT + 1);
  localparam int REM_W   = (SLOT_BITS < 16) ? SLOT_BITS : 16;
  localparam int QDEPTH  = 4 << JW;

  typedef struct packed {
    logic [1:0]       level;
    logic             low;
    logic [REM_W-1:0] rem;
    logic [31:0]      start;
    logic [16:0]      qused;
    logic             qvalid;
    logic [7:0]       waitc;
    logic [7:0]       age;
  } job_t;

  logic [15:0] q0, q1, q2;
  logic [7:0]  au, al;
  logic [CW-1:0] cnt [4];
  logic [JW-1:0] cur;
  logic          running;
  logic [31:0]   timeout;
  logic [31:0]   now;
  logic [JOB_CNT-1:0] present;

  job_t          jmem [JOB_CNT];
  job_t          jrd;
  logic [JW-1:0] qmem [QDEPTH];
  logic [JW-1:0] qrd;

  logic [JW-1:0]    id, tmp;
  logic [REM_W-1:0] trem;
  logic [1:0]       lvt;
  logic [CW-1:0]    i, k, j;

  logic             j_we, q_we;
  logic [JW-1:0]    j_ra, j_wa;
  job_t             j_wd;
  logic [JW+1:0]    q_ra, q_wa;
  logic [JW-1:0]    q_wd;

  logic [CW-1:0] jm1, jp1;
  logic c0nz, c1nz, c2nz, c3nz;
  logic [1:0] sel_lv;

  // arrival
  logic [JW-1:0]    in_idx;
  logic [REM_W-1:0] svc;
  logic             arr_ok;
  job_t             arr_rec;

  // aging
  logic [7:0] w1, ag_wait, ag_age;
  logic       promote;
  job_t       ag_rec;

  // preempt / expiry
  logic [1:0]       lv, target;
  logic             preempt, expire, has_target, reinsert;
  logic [31:0]      ran;
  logic [REM_W-1:0] newrem;
  job_t             pr_rec;

  // dispatch
  logic [16:0] e0, e1, e2, remx, qn, qn2, tq, t;
  job_t        ds_rec;

  assign jm1  = j - 1'b1;
  assign jp1  = j + 1'b1;
  assign c0nz = (cnt[0] != '0);
  assign c1nz = (cnt[1] != '0);
  assign c2nz = (cnt[2] != '0);
  assign c3nz = (cnt[3] != '0);
  assign sel_lv = c0nz ? 2'd0 : c1nz ? 2'd1 : c2nz ? 2'd2 : 2'd3;

  assign in_idx = in_job_id[JW-1:0];
  assign svc    = in_service_slots[REM_W-1:0];
  assign arr_ok = (in_operation == OP_ARRIVE) && (6'(in_job_id) < 6'(JOB_CNT)) &&
                  (svc != '0) && !present[in_idx];

  always_comb begin
    arr_rec        = '0;
    arr_rec.low    = in_low_priority;
    arr_rec.rem    = svc;
  end

  // aging step of one level-3 job
  always_comb begin
    w1      = jrd.qvalid ? 8'd0 : jrd.waitc + 8'd1;
    ag_wait = (w1 == au) ? 8'd0 : w1;
    ag_age  = (w1 == au) ? jrd.age + 8'd1 : jrd.age;
    promote = (ag_age == al);
    ag_rec       = jrd;
    ag_rec.waitc = ag_wait;
    ag_rec.age   = ag_age;
    if (promote) begin
      ag_rec.level  = 2'd1;
      ag_rec.qvalid = 1'b0;
    end
  end

  // charge the running job and pick where it goes
  always_comb begin
    lv      = jrd.level;
    preempt = (lv == 2'd3 && (c0nz || c1nz || c2nz)) ||
              (lv == 2'd2 && (c0nz || c1nz)) ||
              (lv == 2'd1 && c0nz);
    expire  = (now == timeout);
    ran     = now - jrd.start;
    newrem  = (ran >= 32'(jrd.rem)) ? '0 : jrd.rem - ran[REM_W-1:0];
    target     = lv;
    has_target = 1'b1;
    if (!preempt) begin
      case (lv)
        2'd0:    target = jrd.low ? 2'd3 : 2'd1;
        2'd1:    target = 2'd2;
        2'd2:    target = 2'd3;
        default: has_target = 1'b0;   // level-3 expiry leaves
      endcase
    end
    reinsert = (preempt || expire) && has_target && (newrem != '0);
    pr_rec       = jrd;
    pr_rec.rem   = newrem;
    pr_rec.level = target;
    if (target == 2'd1 || target == 2'd2) begin
      pr_rec.qvalid = 1'b0;
    end else if (preempt) begin
      pr_rec.qvalid = 1'b1;
      pr_rec.qused  = (ran[31:16] != '0) ? 17'h10000 : {1'b0, ran[15:0]};
    end
  end

  // run length of the dispatched job
  always_comb begin
    e0   = (q0 == '0) ? 17'd1 : {1'b0, q0};
    e1   = (q1 == '0) ? 17'd1 : {1'b0, q1};
    e2   = (q2 == '0) ? 17'd1 : {1'b0, q2};
    remx = 17'(jrd.rem);
    qn   = (lvt == 2'd1) ? e1 : e2;
    qn2  = !jrd.qvalid ? qn : (jrd.qused >= qn) ? 17'd1 : qn - jrd.qused;
    tq   = (lvt == 2'd0) ? e0 : qn2;
    t    = (lvt == 2'd3) ? remx : ((tq < remx) ? tq : remx);
    ds_rec       = jrd;
    ds_rec.start = now;
  end

  // memory port steering
  always_comb begin
    j_ra = cur;
    j_we = 1'b0;
    j_wa = id;
    j_wd = jrd;
    q_ra = {2'd3, i[JW-1:0]};
    q_we = 1'b0;
    q_wa = {lvt, j[JW-1:0]};
    q_wd = id;
    case (cmd.op)
      CMD_ACCEPT: begin
        if (arr_ok) begin
          j_we = 1'b1;
          j_wa = in_idx;
          j_wd = arr_rec;
          q_we = 1'b1;
          q_wa = {2'd0, cnt[0][JW-1:0]};
          q_wd = in_idx;
        end
      end
      CMD_AG_QRD: q_ra = {2'd3, i[JW-1:0]};
      CMD_AG_JRD: j_ra = qrd;
      CMD_AG_UPD: begin
        j_we = 1'b1;
        j_wd = ag_rec;
        if (!promote) begin
          q_we = 1'b1;
          q_wa = {2'd3, k[JW-1:0]};
        end
      end
      CMD_INS_QRD:  q_ra = {lvt, jm1[JW-1:0]};
      CMD_INS_JRD:  j_ra = qrd;
      CMD_INS_MOVE: begin
        q_we = 1'b1;
        q_wd = tmp;
      end
      CMD_INS_PUT:  q_we = 1'b1;
      CMD_PR_RD:    j_ra = cur;
      CMD_PR_ACT: begin
        if (reinsert) begin
          j_we = 1'b1;
          j_wa = cur;
          j_wd = pr_rec;
        end
      end
      CMD_DS_QRD: q_ra = {sel_lv, {JW{1'b0}}};
      CMD_DS_JRD: j_ra = qrd;
      CMD_DS_RUN: begin
        j_we = 1'b1;
        j_wd = ds_rec;
      end
      CMD_SH_RD: q_ra = {lvt, jp1[JW-1:0]};
      CMD_SH_WR: begin
        q_we = 1'b1;
        q_wd = qrd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (j_we) jmem[j_wa] <= j_wd;
    jrd <= jmem[j_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_wa] <= q_wd;
    qrd <= qmem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q0      <= QUANTUM0_RST;
      q1      <= QUANTUM1_RST;
      q2      <= QUANTUM2_RST;
      au      <= AGE_UNIT_RST;
      al      <= AGE_LIMIT_RST;
      cnt[0]  <= '0;
      cnt[1]  <= '0;
      cnt[2]  <= '0;
      cnt[3]  <= '0;
      cur     <= '0;
      running <= 1'b0;
      timeout <= '0;
      now     <= '0;
      present <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM0:  q0 <= cfg_data;
          CFG_QUANTUM1:  q1 <= cfg_data;
          CFG_QUANTUM2:  q2 <= cfg_data;
          CFG_AGE_UNIT:  au <= cfg_data[7:0];
          CFG_AGE_LIMIT: al <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (cmd.op)
        CMD_ACCEPT: begin
          if (in_operation == OP_TICK) begin
            i <= '0;
            k <= '0;
          end else if (arr_ok) begin
            cnt[0]          <= cnt[0] + 1'b1;
            present[in_idx] <= 1'b1;
          end
        end
        CMD_AG_JRD: id <= qrd;
        CMD_AG_UPD: begin
          i <= i + 1'b1;
          if (promote) begin
            lvt  <= 2'd1;
            trem <= jrd.rem;
            j    <= cnt[1];
          end else begin
            k <= k + 1'b1;
          end
        end
        CMD_AG_END:   cnt[3] <= k;
        CMD_INS_JRD:  tmp <= qrd;
        CMD_INS_MOVE: j <= jm1;
        CMD_INS_PUT:  cnt[lvt] <= cnt[lvt] + 1'b1;
        CMD_PR_ACT: begin
          if (preempt || expire) begin
            running <= 1'b0;
            if (reinsert) begin
              id   <= cur;
              lvt  <= target;
              trem <= newrem;
              j    <= cnt[target];
            end else begin
              present[cur] <= 1'b0;
            end
          end
        end
        CMD_DS_QRD: lvt <= sel_lv;
        CMD_DS_JRD: begin
          id <= qrd;
          j  <= '0;
        end
        CMD_DS_RUN: begin
          timeout  <= now + 32'(t);
          cur      <= id;
          running  <= 1'b1;
          cnt[lvt] <= cnt[lvt] - 1'b1;
        end
        CMD_SH_WR:    j <= jp1;
        CMD_OUT_DONE: now <= now + 32'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.tick        = (in_operation == OP_TICK);
    stat.ag_done     = (i == cnt[3]);
    stat.promote     = promote;
    stat.j_zero      = (j == '0);
    stat.ins_move    = (jrd.rem > trem);
    stat.running     = running;
    stat.reinsert    = reinsert;
    stat.dispatch_go = !running && (c0nz || c1nz || c2nz || c3nz);
    stat.shift_done  = (j == cnt[lvt]);
  end

  assign slot_time    = now;
  assign running_job  = running ? 5'(cur) : 5'd0;
  assign machine_idle = !running;
  assign all_empty    = !running && !c0nz && !c1nz && !c2nz && !c3nz;

  `MLFQ_ASSERT_IMP(a_job_census, clk, rst, cmd.op == CMD_ACCEPT, $countones(present) == (int'(cnt[0]) + int'(cnt[1]) + int'(cnt[2]) + int'(cnt[3]) + int'(running)))
  `MLFQ_ASSERT_IMP(a_run_present, clk, rst, running, present[cur])
  `MLFQ_ASSERT_IMP(a_age_nonempty, clk, rst, cmd.op == CMD_AG_UPD, cnt[3] != '0)

endmodule
